/* hw/rtl/aca_pkg.sv */
// shared widths and register codes for the antialiased circle alpha core
package aca_pkg;

  localparam int RAD_W   = 6;
  localparam int COORD_W = 7;
  localparam int ALPHA_W = 8;
  localparam int MAG_W   = 7;
  localparam int SQ_W    = 2 * MAG_W + 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_RING   = 1'b1
  } reg_idx_t;

endpackage

/* hw/rtl/antialiased_circle_alpha_core.sv */
// top level: antialiased circle alpha generator with register port
// One pixel request is taken every cycle and one alpha leaves every cycle while
// out_tready is high; a request's alpha passes through one offset stage,
// DIST_FRAC_BITS+8 square root cells, one weight stage and the output
// register. The square root is a chain of identical cells, one root bit per
// cell, each with its own handshake so that a stalled output only stops the
// cells that hold work. Radius above RADIUS_MAX is clamped to RADIUS_MAX.
// Registers: radius at byte address 0, ring mode at 4; write them only idle.
module antialiased_circle_alpha_core #(
  parameter int RADIUS_MAX     = 32,
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [aca_pkg::IN_TDATA_W-1:0]  in_tdata,   // pixel_x, pixel_y, zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [aca_pkg::OUT_TDATA_W-1:0] out_tdata,  // alpha
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [aca_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [aca_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [aca_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                           cfg_pready
);
  import aca_pkg::*;

  localparam int F      = DIST_FRAC_BITS;
  localparam int ROOT_W = F + 8;
  localparam int V_W    = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  logic [RAD_W-1:0]   radius_r;
  logic               ring_r;
  logic [RAD_W-1:0]   r_sat;
  reg_idx_t           idx;

  logic [ROOT_W:0]    cv;
  logic [ROOT_W:0]    cr;
  logic [V_W-1:0]     cvv  [ROOT_W+1];
  logic [REM_W-1:0]   crem [ROOT_W+1];
  logic [ROOT_W-1:0]  cq   [ROOT_W+1];

  logic               a_valid, a_ready;
  logic [F:0]         a_k;
  logic               out_valid_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [F+8:0]       prod;

  // register port
  assign idx        = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (idx)
      REG_RADIUS: cfg_prdata = CFG_DATA_W'(radius_r);
      REG_RING:   cfg_prdata = CFG_DATA_W'(ring_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(1);
      ring_r   <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (idx)
        REG_RADIUS: radius_r <= cfg_pwdata[RAD_W-1:0];
        REG_RING:   ring_r   <= cfg_pwdata[0];
        default:    ;
      endcase
    end
  end

  assign r_sat = ({2'b00, radius_r} > 8'(RADIUS_MAX)) ? RAD_W'(RADIUS_MAX) : radius_r;

  aca_prep #(.FRAC_W(F)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pixel_x   (in_tdata[COORD_W-1:0]),
    .pixel_y   (in_tdata[2*COORD_W-1:COORD_W]),
    .radius    (r_sat),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_v     (cvv[0])
  );

  assign crem[0] = '0;
  assign cq[0]   = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    aca_root_cell #(.ROOT_W(ROOT_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_v      (cvv[i]),
      .in_rem    (crem[i]),
      .in_q      (cq[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_v     (cvv[i+1]),
      .out_rem   (crem[i+1]),
      .out_q     (cq[i+1])
    );
  end

  aca_alpha #(.FRAC_W(F)) u_alpha (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv[ROOT_W]),
    .in_ready  (cr[ROOT_W]),
    .distance  (cq[ROOT_W]),
    .radius    (r_sat),
    .ring      (ring_r),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_k     (a_k)
  );

  // alpha = floor(k * 255 / 2^F)
  assign prod    = ({a_k, 8'h00}) - (F+9)'(a_k);
  assign a_ready = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_ready) begin
      out_valid_r <= a_valid;
    end
    if (a_ready && a_valid) begin
      alpha_r <= prod[F+7:F];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = alpha_r;

endmodule

/* hw/rtl/aca_prep.sv */
// offset from the centre and sum of squares, first pipeline stage
module aca_prep #(
  parameter int FRAC_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [aca_pkg::COORD_W-1:0] pixel_x,
  input  logic [aca_pkg::COORD_W-1:0] pixel_y,
  input  logic [aca_pkg::RAD_W-1:0]   radius,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*(FRAC_W+8)-1:0]    out_v
);
  import aca_pkg::*;

  localparam int V_W = 2 * (FRAC_W + 8);

  logic               valid_r;
  logic [V_W-1:0]     v_r;
  logic signed [8:0]  dx, dy;
  logic [8:0]         ax, ay;
  logic [SQ_W-1:0]    sq;

  always_comb begin
    dx = $signed({2'b00, pixel_x}) - $signed({3'b000, radius}) - 9'sd1;
    dy = $signed({2'b00, pixel_y}) - $signed({3'b000, radius}) - 9'sd1;
    ax = dx[8] ? 9'(-dx) : 9'(dx);
    ay = dy[8] ? 9'(-dy) : 9'(dy);
    sq = SQ_W'(ax[MAG_W-1:0] * ax[MAG_W-1:0]) + SQ_W'(ay[MAG_W-1:0] * ay[MAG_W-1:0]);
  end

  assign in_ready  = ~valid_r | out_ready;
  assign out_valid = valid_r;
  assign out_v     = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      v_r <= {{(V_W-SQ_W-2*FRAC_W){1'b0}}, sq, {(2*FRAC_W){1'b0}}};
    end
  end

endmodule

/* hw/rtl/aca_root_cell.sv */
// one digit of the square root chain
module aca_root_cell #(
  parameter int ROOT_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2*ROOT_W-1:0] in_v,
  input  logic [ROOT_W+2:0]   in_rem,
  input  logic [ROOT_W-1:0]   in_q,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2*ROOT_W-1:0] out_v,
  output logic [ROOT_W+2:0]   out_rem,
  output logic [ROOT_W-1:0]   out_q
);
  localparam int V_W   = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic              valid_r;
  logic [V_W-1:0]    v_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] q_r;
  logic [REM_W-1:0]  rem_t, trial;
  logic              ge;

  always_comb begin
    rem_t = {in_rem[REM_W-3:0], in_v[V_W-1:V_W-2]};
    trial = {1'b0, in_q, 2'b01};
    ge    = rem_t >= trial;
  end

  assign in_ready  = ~valid_r | out_ready;
  assign out_valid = valid_r;
  assign out_v     = v_r;
  assign out_rem   = rem_r;
  assign out_q     = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      v_r   <= {in_v[V_W-3:0], 2'b00};
      rem_r <= ge ? rem_t - trial : rem_t;
      q_r   <= {in_q[ROOT_W-2:0], ge};
    end
  end

endmodule

/* hw/rtl/aca_alpha.sv */
// coverage weight from distance and radius, filled or ring profile
module aca_alpha #(
  parameter int FRAC_W = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FRAC_W+7:0]        distance,
  input  logic [aca_pkg::RAD_W-1:0] radius,
  input  logic                     ring,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRAC_W:0]          out_k
);
  import aca_pkg::*;

  localparam int ROOT_W = FRAC_W + 8;
  localparam int CW     = ROOT_W + 1;

  logic            valid_r;
  logic [FRAC_W:0] k_r;
  logic [CW-1:0]   d, rq, one, half, lim, t, diff;
  logic [FRAC_W:0] k;

  always_comb begin
    d    = {1'b0, distance};
    rq   = CW'({radius, {FRAC_W{1'b0}}});
    one  = CW'(1) << FRAC_W;
    half = CW'(1) << (FRAC_W - 1);
    lim  = rq + half;
    t    = lim - d;
    diff = (d >= rq) ? d - rq : rq - d;
    if (ring) begin
      k = (diff >= one) ? '0 : (FRAC_W+1)'(one - diff);
    end else if (d > lim) begin
      k = '0;
    end else begin
      k = (t >= one) ? (FRAC_W+1)'(one) : (FRAC_W+1)'(t);
    end
  end

  assign in_ready  = ~valid_r | out_ready;
  assign out_valid = valid_r;
  assign out_k     = k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      k_r <= k;
    end
  end

endmodule
